// File: rtl/ddo_pkg.sv
// ddo_pkg: shared types, codes and constants of the odometry integrator
// used by the channel interfaces and the integrator top level; depends on nothing
package ddo_pkg;

  localparam int unsigned SincosSteps = 16;
  localparam int unsigned CordicMax   = 32;
  localparam int unsigned CordicSteps = (SincosSteps > CordicMax) ? CordicMax : SincosSteps;
  localparam int unsigned StepW       = $clog2(CordicMax);
  localparam logic [StepW-1:0] LastStep = StepW'(CordicSteps - 1);

  localparam logic [31:0] GainInv    = 32'd2608131496;
  localparam logic [15:0] ScaleReset = 16'd655;
  localparam logic [23:0] TpmReset   = 24'd38631;

  localparam int unsigned ModeW  = 2;
  localparam int unsigned ValueW = 24;
  localparam int unsigned ElapsW = 24;
  localparam int unsigned PosW   = 48;
  localparam int unsigned AngW   = 32;
  localparam int unsigned CfgAw  = 3;

  typedef enum logic [ModeW-1:0] {
    MODE_RIGHT_DIR   = 2'd0,
    MODE_LEFT_DIR    = 2'd1,
    MODE_LEFT_SPEED  = 2'd2,
    MODE_RIGHT_SPEED = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    OP_SPD_L = 3'd0,
    OP_RATE  = 3'd1,
    OP_DIST  = 3'd2,
    OP_GAIN  = 3'd3,
    OP_HEAD  = 3'd4,
    OP_SPD_R = 3'd5
  } op_t;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MUL  = 6'b000010,
    S_POST = 6'b000100,
    S_CORD = 6'b001000,
    S_POS  = 6'b010000,
    S_EMIT = 6'b100000
  } state_t;

  localparam logic CfgRegScale = 1'b0;
  localparam logic CfgRegTpm   = 1'b1;

  // arctangent of 2^-k as binary angle
  function automatic logic [31:0] atan_lookup(input logic [StepW-1:0] k);
    logic [31:0] a;
    unique case (k)
      5'd0:  a = 32'h20000000;
      5'd1:  a = 32'h12E4051E;
      5'd2:  a = 32'h09FB385B;
      5'd3:  a = 32'h051111D4;
      5'd4:  a = 32'h028B0D43;
      5'd5:  a = 32'h0145D7E1;
      5'd6:  a = 32'h00A2F61E;
      5'd7:  a = 32'h00517C55;
      5'd8:  a = 32'h0028BE53;
      5'd9:  a = 32'h00145F2F;
      5'd10: a = 32'h000A2F98;
      5'd11: a = 32'h000517CC;
      5'd12: a = 32'h00028BE6;
      5'd13: a = 32'h000145F3;
      5'd14: a = 32'h0000A2FA;
      5'd15: a = 32'h0000517D;
      5'd16: a = 32'h000028BE;
      5'd17: a = 32'h0000145F;
      5'd18: a = 32'h00000A30;
      5'd19: a = 32'h00000518;
      5'd20: a = 32'h0000028C;
      5'd21: a = 32'h00000146;
      5'd22: a = 32'h000000A3;
      5'd23: a = 32'h00000051;
      5'd24: a = 32'h00000029;
      5'd25: a = 32'h00000014;
      5'd26: a = 32'h0000000A;
      5'd27: a = 32'h00000005;
      5'd28: a = 32'h00000003;
      5'd29: a = 32'h00000001;
      5'd30: a = 32'h00000001;
      5'd31: a = 32'h00000000;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

endpackage

// File: rtl/ddo_ifs.sv
// ddo_ifs: valid/ready channel interfaces for encoder events and pose results
// depends on ddo_pkg for field widths
interface ddo_in_if;
  logic                         valid;
  logic                         ready;
  logic [ddo_pkg::ModeW-1:0]    mode;
  logic [ddo_pkg::ValueW-1:0]   value;
  logic [ddo_pkg::ElapsW-1:0]   elapsed;
  modport source (output valid, mode, value, elapsed, input ready);
  modport sink   (input valid, mode, value, elapsed, output ready);
endinterface

interface ddo_out_if;
  logic                         valid;
  logic                         ready;
  logic [ddo_pkg::PosW-1:0]     x_pos;
  logic [ddo_pkg::PosW-1:0]     y_pos;
  logic [ddo_pkg::AngW-1:0]     heading;
  modport source (output valid, x_pos, y_pos, heading, input ready);
  modport sink   (input valid, x_pos, y_pos, heading, output ready);
endinterface

// File: rtl/diff_drive_odometry_integrator_unit.sv
// diff_drive_odometry_integrator_unit: two-wheel dead-reckoning odometry
// uses ddo_pkg (codes, constants, atan table) and ddo_ifs (channels)
//
//  channel | dir | carries                     | handshake
//  in_ch   | in  | mode, value, elapsed        | valid/ready
//  out_ch  | out | x_pos, y_pos, heading       | valid/ready, output register
//  cfg_*   | in  | speed_scale, turns_per_metre| apb, pready tied high
//
// direction events only set a wheel sign; a left speed event runs two products;
// a right speed event runs four products on the shared
// 24x24 multiplier (4 partial products each) plus one cordic step per cycle.
// rst_n is synchronous; it clears pose, speeds, signs and restores register defaults.
// a pose beat waiting on out_ch.ready holds the next right speed event in its last state.
module diff_drive_odometry_integrator_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  ddo_in_if.sink                    in_ch,
  ddo_out_if.source                 out_ch,
  input  logic                      cfg_psel,
  input  logic                      cfg_penable,
  input  logic                      cfg_pwrite,
  input  logic [ddo_pkg::CfgAw-1:0] cfg_paddr,
  input  logic [31:0]               cfg_pwdata,
  output logic [31:0]               cfg_prdata,
  output logic                      cfg_pready
);

  ddo_pkg::state_t state_r, state_nxt;
  ddo_pkg::op_t    op_r, op_nxt;
  logic [2:0]  mstep_r, mstep_nxt;
  logic [1:0]  pp_sel_r, pp_sel_nxt;
  logic [47:0] mul_r, mul_nxt;
  logic [79:0] acc_r, acc_nxt;
  logic [47:0] opa_r, opa_nxt;
  logic [31:0] opb_r, opb_nxt;
  logic        neg_r, neg_nxt;
  logic        zero_r, zero_nxt;
  logic [1:0]  rsign_r, rsign_nxt;
  logic [1:0]  lsign_r, lsign_nxt;
  logic signed [39:0] rspd_r, rspd_nxt;
  logic signed [39:0] lspd_r, lspd_nxt;
  logic signed [39:0] mean_r, mean_nxt;
  logic signed [39:0] turn_r, turn_nxt;
  logic signed [47:0] posx_r, posx_nxt;
  logic signed [47:0] posy_r, posy_nxt;
  logic [31:0] ang_r, ang_nxt;
  logic signed [49:0] cx_r, cx_nxt;
  logic signed [49:0] cy_r, cy_nxt;
  logic signed [33:0] z_r, z_nxt;
  logic [ddo_pkg::StepW-1:0] k_r, k_nxt;
  logic [23:0] val_r, val_nxt;
  logic [23:0] el_r, el_nxt;
  logic [15:0] scale_r, scale_nxt;
  logic [23:0] tpm_r, tpm_nxt;
  logic        ovalid_r, ovalid_nxt;
  logic [47:0] ox_r, ox_nxt;
  logic [47:0] oy_r, oy_nxt;
  logic [31:0] oh_r, oh_nxt;

  logic [23:0] a_part, b_part;
  logic [79:0] pp_sh;
  logic signed [80:0] prod_s;
  logic signed [39:0] spd_new;
  logic signed [40:0] diff, ssum;
  logic [40:0] diff_mag;
  logic signed [48:0] dist_s;
  logic [47:0] dist_mag;
  logic [47:0] km;
  logic signed [49:0] k0;
  logic [31:0] ang_rot, ang_res;
  logic [1:0]  quad;
  logic signed [49:0] xs, ys;
  logic signed [33:0] atan_v;
  logic signed [49:0] xsum, ysum;
  logic [23:0] in_mag, val_mag;
  logic [39:0] mean_mag, turn_mag;
  logic        rate_sat;
  logic        in_fire, cfg_wr;

  assign in_fire    = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == ddo_pkg::S_IDLE);
  assign out_ch.valid   = ovalid_r;
  assign out_ch.x_pos   = ox_r;
  assign out_ch.y_pos   = oy_r;
  assign out_ch.heading = oh_r;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[2] == ddo_pkg::CfgRegTpm) ? {8'd0, tpm_r} : {16'd0, scale_r};

  // shared multiplier operand selection, one partial product per cycle
  assign a_part = mstep_r[0] ? opa_r[47:24] : opa_r[23:0];
  assign b_part = mstep_r[1] ? {16'd0, opb_r[31:24]} : opb_r[23:0];

  always_comb begin
    unique case (pp_sel_r)
      2'd0:    pp_sh = {32'd0, mul_r};
      2'd1:    pp_sh = {8'd0, mul_r, 24'd0};
      2'd2:    pp_sh = {8'd0, mul_r, 24'd0};
      2'd3:    pp_sh = {mul_r[31:0], 48'd0};
      default: pp_sh = {32'd0, mul_r};
    endcase
  end

  assign prod_s  = neg_r ? -$signed({1'b0, acc_r}) : $signed({1'b0, acc_r});
  assign spd_new = zero_r ? 40'sd0 : prod_s[39:0];

  assign in_mag   = in_ch.value[23] ? 24'(-in_ch.value) : in_ch.value;
  assign val_mag  = val_r[23] ? 24'(-val_r) : val_r;
  assign mean_mag = mean_r[39] ? 40'(-mean_r) : 40'(mean_r);
  assign turn_mag = turn_r[39] ? 40'(-turn_r) : 40'(turn_r);

  assign diff     = 41'(rspd_r) - 41'(spd_new);
  assign ssum     = 41'(rspd_r) + 41'(spd_new);
  assign diff_mag = diff[40] ? 41'(-diff) : 41'(diff);
  assign rate_sat = |acc_r[79:47];

  assign dist_s   = prod_s[64:16];
  assign dist_mag = dist_s[48] ? 48'(-dist_s) : dist_s[47:0];

  assign km      = acc_r[79:32];
  assign k0      = neg_r ? -$signed({2'b00, km}) : $signed({2'b00, km});
  assign ang_rot = ang_r + 32'h2000_0000;
  assign quad    = ang_rot[31:30];
  assign ang_res = ang_r - {quad, 30'd0};

  assign xs     = cx_r >>> k_r;
  assign ys     = cy_r >>> k_r;
  assign atan_v = $signed({2'b00, ddo_pkg::atan_lookup(k_r)});

  assign xsum = 50'(posx_r) + (cx_r >>> 8);
  assign ysum = 50'(posy_r) + (cy_r >>> 8);

  always_comb begin
    state_nxt = state_r;  op_nxt = op_r;  mstep_nxt = mstep_r;  pp_sel_nxt = pp_sel_r;
    mul_nxt = mul_r;  acc_nxt = acc_r;  opa_nxt = opa_r;  opb_nxt = opb_r;
    neg_nxt = neg_r;  zero_nxt = zero_r;  rsign_nxt = rsign_r;  lsign_nxt = lsign_r;
    rspd_nxt = rspd_r;  lspd_nxt = lspd_r;  mean_nxt = mean_r;  turn_nxt = turn_r;
    posx_nxt = posx_r;  posy_nxt = posy_r;  ang_nxt = ang_r;
    cx_nxt = cx_r;  cy_nxt = cy_r;  z_nxt = z_r;  k_nxt = k_r;
    val_nxt = val_r;  el_nxt = el_r;  scale_nxt = scale_r;  tpm_nxt = tpm_r;
    ovalid_nxt = ovalid_r;  ox_nxt = ox_r;  oy_nxt = oy_r;  oh_nxt = oh_r;

    if (ovalid_r && out_ch.ready) begin
      ovalid_nxt = 1'b0;
    end

    if (cfg_wr) begin
      if (cfg_paddr[2] == ddo_pkg::CfgRegTpm) begin
        tpm_nxt = cfg_pwdata[23:0];
      end else begin
        scale_nxt = cfg_pwdata[15:0];
      end
    end

    unique case (state_r)
      ddo_pkg::S_IDLE: begin
        if (in_fire) begin
          val_nxt   = in_ch.value;
          el_nxt    = in_ch.elapsed;
          acc_nxt   = '0;
          mstep_nxt = '0;
          unique case (ddo_pkg::mode_t'(in_ch.mode))
            ddo_pkg::MODE_RIGHT_DIR: rsign_nxt = in_ch.value[23] ? 2'b11 : 2'b01;
            ddo_pkg::MODE_LEFT_DIR:  lsign_nxt = in_ch.value[23] ? 2'b11 : 2'b01;
            ddo_pkg::MODE_LEFT_SPEED: begin
              opa_nxt   = {24'd0, in_mag};
              opb_nxt   = {16'd0, scale_r};
              neg_nxt   = in_ch.value[23] ^ lsign_r[1];
              zero_nxt  = (lsign_r == 2'b00);
              op_nxt    = ddo_pkg::OP_SPD_L;
              state_nxt = ddo_pkg::S_MUL;
            end
            ddo_pkg::MODE_RIGHT_SPEED: begin
              opa_nxt   = {8'd0, mean_mag};
              opb_nxt   = {8'd0, in_ch.elapsed};
              neg_nxt   = mean_r[39];
              zero_nxt  = 1'b0;
              op_nxt    = ddo_pkg::OP_DIST;
              state_nxt = ddo_pkg::S_MUL;
            end
            default: ;
          endcase
        end
      end

      ddo_pkg::S_MUL: begin
        if (mstep_r != 3'd4) begin
          mul_nxt    = a_part * b_part;
          pp_sel_nxt = mstep_r[1:0];
        end
        if (mstep_r != 3'd0) begin
          acc_nxt = acc_r + pp_sh;
        end
        mstep_nxt = mstep_r + 3'd1;
        if (mstep_r == 3'd4) begin
          state_nxt = ddo_pkg::S_POST;
        end
      end

      ddo_pkg::S_POST: begin
        acc_nxt   = '0;
        mstep_nxt = '0;
        unique case (op_r)
          ddo_pkg::OP_SPD_L: begin
            lspd_nxt  = spd_new;
            mean_nxt  = ssum[40:1];
            opa_nxt   = {7'd0, diff_mag};
            opb_nxt   = {8'd0, tpm_r};
            neg_nxt   = diff[40];
            zero_nxt  = 1'b0;
            op_nxt    = ddo_pkg::OP_RATE;
            state_nxt = ddo_pkg::S_MUL;
          end
          ddo_pkg::OP_RATE: begin
            if (neg_r) begin
              turn_nxt = rate_sat ? {1'b1, 39'd0} : -$signed({1'b0, acc_r[46:8]});
            end else begin
              turn_nxt = rate_sat ? {1'b0, {39{1'b1}}} : $signed({1'b0, acc_r[46:8]});
            end
            state_nxt = ddo_pkg::S_IDLE;
          end
          ddo_pkg::OP_DIST: begin
            opa_nxt   = dist_mag;
            opb_nxt   = ddo_pkg::GainInv;
            neg_nxt   = dist_s[48];
            op_nxt    = ddo_pkg::OP_GAIN;
            state_nxt = ddo_pkg::S_MUL;
          end
          ddo_pkg::OP_GAIN: begin
            // quarter-turn reduction puts the residual angle within one octant pair
            cx_nxt = '0;
            cy_nxt = '0;
            unique case (quad)
              2'd0:    cx_nxt = k0;
              2'd1:    cy_nxt = k0;
              2'd2:    cx_nxt = -k0;
              2'd3:    cy_nxt = -k0;
              default: cx_nxt = k0;
            endcase
            z_nxt     = 34'($signed(ang_res));
            k_nxt     = '0;
            state_nxt = ddo_pkg::S_CORD;
          end
          ddo_pkg::OP_HEAD: begin
            ang_nxt   = ang_r + prod_s[47:16];
            opa_nxt   = {24'd0, val_mag};
            opb_nxt   = {16'd0, scale_r};
            neg_nxt   = val_r[23] ^ rsign_r[1];
            zero_nxt  = (rsign_r == 2'b00);
            op_nxt    = ddo_pkg::OP_SPD_R;
            state_nxt = ddo_pkg::S_MUL;
          end
          ddo_pkg::OP_SPD_R: begin
            rspd_nxt  = spd_new;
            state_nxt = ddo_pkg::S_EMIT;
          end
          default: state_nxt = ddo_pkg::S_IDLE;
        endcase
      end

      ddo_pkg::S_CORD: begin
        if (z_r >= 0) begin
          cx_nxt = cx_r - ys;
          cy_nxt = cy_r + xs;
          z_nxt  = z_r - atan_v;
        end else begin
          cx_nxt = cx_r + ys;
          cy_nxt = cy_r - xs;
          z_nxt  = z_r + atan_v;
        end
        k_nxt = k_r + 1'b1;
        if (k_r == ddo_pkg::LastStep) begin
          state_nxt = ddo_pkg::S_POS;
        end
      end

      ddo_pkg::S_POS: begin
        // saturate when the top three bits disagree
        if (xsum[49:47] == 3'b000 || xsum[49:47] == 3'b111) begin
          posx_nxt = xsum[47:0];
        end else begin
          posx_nxt = xsum[49] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
        end
        if (ysum[49:47] == 3'b000 || ysum[49:47] == 3'b111) begin
          posy_nxt = ysum[47:0];
        end else begin
          posy_nxt = ysum[49] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
        end
        opa_nxt   = {8'd0, turn_mag};
        opb_nxt   = {8'd0, el_r};
        neg_nxt   = turn_r[39];
        zero_nxt  = 1'b0;
        op_nxt    = ddo_pkg::OP_HEAD;
        acc_nxt   = '0;
        mstep_nxt = '0;
        state_nxt = ddo_pkg::S_MUL;
      end

      ddo_pkg::S_EMIT: begin
        if (!ovalid_r || out_ch.ready) begin
          ovalid_nxt = 1'b1;
          ox_nxt     = posx_r;
          oy_nxt     = posy_r;
          oh_nxt     = ang_r;
          state_nxt  = ddo_pkg::S_IDLE;
        end
      end

      default: state_nxt = ddo_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ddo_pkg::S_IDLE;
      ovalid_r <= 1'b0;
      rsign_r  <= 2'b00;
      lsign_r  <= 2'b00;
      rspd_r   <= '0;
      lspd_r   <= '0;
      mean_r   <= '0;
      turn_r   <= '0;
      posx_r   <= '0;
      posy_r   <= '0;
      ang_r    <= '0;
      scale_r  <= ddo_pkg::ScaleReset;
      tpm_r    <= ddo_pkg::TpmReset;
      mstep_r  <= '0;
      k_r      <= '0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
      rsign_r  <= rsign_nxt;
      lsign_r  <= lsign_nxt;
      rspd_r   <= rspd_nxt;
      lspd_r   <= lspd_nxt;
      mean_r   <= mean_nxt;
      turn_r   <= turn_nxt;
      posx_r   <= posx_nxt;
      posy_r   <= posy_nxt;
      ang_r    <= ang_nxt;
      scale_r  <= scale_nxt;
      tpm_r    <= tpm_nxt;
      mstep_r  <= mstep_nxt;
      k_r      <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    pp_sel_r <= pp_sel_nxt;
    mul_r    <= mul_nxt;
    acc_r    <= acc_nxt;
    opa_r    <= opa_nxt;
    opb_r    <= opb_nxt;
    neg_r    <= neg_nxt;
    zero_r   <= zero_nxt;
    cx_r     <= cx_nxt;
    cy_r     <= cy_nxt;
    z_r      <= z_nxt;
    val_r    <= val_nxt;
    el_r     <= el_nxt;
    ox_r     <= ox_nxt;
    oy_r     <= oy_nxt;
    oh_r     <= oh_nxt;
  end

endmodule
